FILE: rtl/teg_pkg.sv
// ----------------------------------------------------------------------------
// teg_pkg
// Shared types and constants of the tracker envelope generator.
// ----------------------------------------------------------------------------
package teg_pkg;

    localparam int MAX_POINTS_DEF = 12;
    localparam int X_W            = 16;
    localparam int Y_W            = 7;
    localparam int FC_W           = 17;
    localparam int NUM_W          = 23;
    localparam int DIV_CNT_W      = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [FC_W-1:0] FADE_FULL  = 17'd65536;
    localparam logic [Y_W-1:0]  LEVEL_FULL = 7'd64;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_KEYOFF = 2'd2;
    localparam logic [1:0] OP_LOAD   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_ON     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUS_ON     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ON    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP  = 3'd7;

    typedef enum logic [2:0] {
        PH_PLAYING    = 3'd0,
        PH_SUSTAINING = 3'd1,
        PH_RELEASING  = 3'd2,
        PH_FADING     = 3'd3,
        PH_FINISHED   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0]     op;
        logic [3:0]     point_index;
        logic [X_W-1:0] point_x;
        logic [Y_W-1:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic [Y_W-1:0] level;
        logic [2:0]     phase;
        logic           active;
    } out_item_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START_BEGIN,
        CMD_START_LEVEL,
        CMD_KEYOFF,
        CMD_FINISHED_TICK,
        CMD_FLAT,
        CMD_FADE,
        CMD_MUL_FLAT,
        CMD_READ_LAST,
        CMD_MUL_LAST,
        CMD_READ_SUS,
        CMD_SUS_LEVEL,
        CMD_SCAN_INIT,
        CMD_SCAN_STEP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_INTERP,
        CMD_END_FADE,
        CMD_MUL_LEVEL,
        CMD_READ_LEND,
        CMD_LEND_CHECK,
        CMD_LSTART,
        CMD_END_CHECK,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    accept;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        phase_t     phase;
        logic       env_on;
        logic       sustain_on;
        logic       sus_hit;
        logic       scan_last;
        logic       found;
        logic       div_last;
        logic       out_free;
    } status_t;

endpackage

FILE: rtl/teg_ram.sv
// ----------------------------------------------------------------------------
// teg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module teg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/teg_datapath.sv
// ----------------------------------------------------------------------------
// teg_datapath
// Envelope state, configuration registers, point table, segment scan,
// serial divider and fade arithmetic, driven by controller commands.
// ----------------------------------------------------------------------------
module teg_datapath #(
    parameter int MAX_POINTS = teg_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  teg_pkg::cmd_t                       cmd,
    output teg_pkg::status_t                    status,
    input  teg_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output teg_pkg::out_item_t                  out_data,
    input  logic                                cfg_we,
    input  logic [teg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [teg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int X_W   = teg_pkg::X_W;
    localparam int Y_W   = teg_pkg::Y_W;
    localparam int FC_W  = teg_pkg::FC_W;
    localparam int NUM_W = teg_pkg::NUM_W;
    localparam int CNT_W = teg_pkg::DIV_CNT_W;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [3:0] v);
        if (32'(v) < MAX_POINTS)
            return IDX_W'(v);
        else
            return IDX_W'(MAX_POINTS - 1);
    endfunction

    logic [3:0]       num_points_reg, sustain_idx_reg, lstart_idx_reg, lend_idx_reg;
    logic             env_on_reg, sus_on_reg, loop_on_reg;
    logic [15:0]      fade_step_reg;

    logic [X_W-1:0]   pos_reg, pos_next;
    logic [Y_W-1:0]   level_reg, level_next;
    logic [FC_W-1:0]  fc_reg, fc_next;
    teg_pkg::phase_t  phase_reg, phase_next;
    logic             act_reg, act_next;

    logic [X_W-1:0]   prev_x_reg, prev_x_next;
    logic [Y_W-1:0]   prev_y_reg, prev_y_next;
    logic [X_W-1:0]   dp_reg, dp_next;
    logic [X_W-1:0]   dx_reg, dx_next;
    logic [Y_W-1:0]   y0_reg, y0_next;
    logic [Y_W-1:0]   mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             found_reg, found_next;
    logic             jump_reg, jump_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [X_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    teg_pkg::out_item_t  out_data_reg, out_data_next;

    logic [IDX_W:0]      n_pts;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    raddr;
    logic [X_W+Y_W-1:0]  rdata;
    logic [X_W-1:0]      rd_x;
    logic [Y_W-1:0]      rd_y;
    logic                ram_we;
    logic [FC_W-1:0]     fc_faded;
    logic [X_W:0]        rem_sh;
    logic                div_ge;
    logic [Y_W:0]        dy;
    logic [23:0]         mul_prod;
    logic [Y_W-1:0]      mul_src;
    logic                out_free;

    assign rd_x = rdata[X_W+Y_W-1:Y_W];
    assign rd_y = rdata[Y_W-1:0];

    always_comb
    begin
        if (num_points_reg == 4'd0)
            n_pts = (IDX_W+1)'(1);
        else if (32'(num_points_reg) > MAX_POINTS)
            n_pts = (IDX_W+1)'(MAX_POINTS);
        else
            n_pts = (IDX_W+1)'(num_points_reg);
    end
    assign last_idx = IDX_W'(n_pts - (IDX_W+1)'(1));

    assign ram_we = (cmd.op == teg_pkg::CMD_LOAD) &&
                    (32'(in_data.point_index) < MAX_POINTS);

    always_comb
    begin
        case (cmd.op)
            teg_pkg::CMD_READ_SUS:   raddr = clamp_idx(sustain_idx_reg);
            teg_pkg::CMD_SCAN_STEP:  raddr = (idx_reg == last_idx) ? '0 :
                                             IDX_W'(idx_reg + 1'b1);
            teg_pkg::CMD_READ_LAST:  raddr = last_idx;
            teg_pkg::CMD_READ_LEND:  raddr = clamp_idx(lend_idx_reg);
            teg_pkg::CMD_LEND_CHECK: raddr = clamp_idx(lstart_idx_reg);
            default:                 raddr = '0;
        endcase
    end

    teg_ram #(
        .WIDTH (X_W + Y_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(in_data.point_index)),
        .wdata ({in_data.point_x, in_data.point_y}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign fc_faded = (fc_reg > {1'b0, fade_step_reg}) ? FC_W'(fc_reg - {1'b0, fade_step_reg})
                                                       : '0;
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge   = rem_sh >= {1'b0, dx_reg};
    assign dy       = {1'b0, rd_y} - {1'b0, prev_y_reg};
    assign mul_src  = (cmd.op == teg_pkg::CMD_MUL_LAST) ? rd_y : level_reg;
    assign mul_prod = 24'(mul_src) * 24'(fc_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        pos_next       = pos_reg;
        level_next     = level_reg;
        fc_next        = fc_reg;
        phase_next     = phase_reg;
        act_next       = act_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        dp_next        = dp_reg;
        dx_next        = dx_reg;
        y0_next        = y0_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        found_next     = found_reg;
        jump_next      = jump_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cmd.accept)
        begin
            act_next = 1'b1;
        end

        case (cmd.op)
            teg_pkg::CMD_START_BEGIN:
            begin
                phase_next = teg_pkg::PH_PLAYING;
                pos_next   = '0;
                fc_next    = teg_pkg::FADE_FULL;
            end
            teg_pkg::CMD_START_LEVEL:
            begin
                level_next = env_on_reg ? rd_y : teg_pkg::LEVEL_FULL;
            end
            teg_pkg::CMD_KEYOFF:
            begin
                if (phase_reg == teg_pkg::PH_PLAYING || phase_reg == teg_pkg::PH_SUSTAINING)
                    phase_next = teg_pkg::PH_RELEASING;
            end
            teg_pkg::CMD_FINISHED_TICK:
            begin
                level_next = '0;
                act_next   = 1'b0;
            end
            teg_pkg::CMD_FLAT:
            begin
                level_next = teg_pkg::LEVEL_FULL;
            end
            teg_pkg::CMD_FADE, teg_pkg::CMD_READ_LAST:
            begin
                fc_next = fc_faded;
            end
            teg_pkg::CMD_MUL_FLAT:
            begin
                level_next = fc_reg[FC_W-1:FC_W-Y_W];
                if (fc_reg == '0)
                    phase_next = teg_pkg::PH_FINISHED;
            end
            teg_pkg::CMD_MUL_LAST, teg_pkg::CMD_MUL_LEVEL:
            begin
                level_next = mul_prod[22:16];
                if (fc_reg == '0)
                    phase_next = teg_pkg::PH_FINISHED;
            end
            teg_pkg::CMD_SUS_LEVEL:
            begin
                level_next = rd_y;
                phase_next = teg_pkg::PH_SUSTAINING;
            end
            teg_pkg::CMD_SCAN_INIT:
            begin
                idx_next   = '0;
                found_next = 1'b0;
            end
            teg_pkg::CMD_SCAN_STEP:
            begin
                if (idx_reg != '0 && !found_reg && pos_reg >= prev_x_reg && pos_reg < rd_x)
                begin
                    found_next = 1'b1;
                    dp_next    = pos_reg - prev_x_reg;
                    dx_next    = rd_x - prev_x_reg;
                    y0_next    = prev_y_reg;
                    neg_next   = dy[Y_W];
                    mag_next   = dy[Y_W] ? Y_W'(-dy) : dy[Y_W-1:0];
                end
                prev_x_next = rd_x;
                prev_y_next = rd_y;
                idx_next    = IDX_W'(idx_reg + 1'b1);
            end
            teg_pkg::CMD_DIV_INIT:
            begin
                num_next = NUM_W'(mag_reg) * NUM_W'(dp_reg);
                rem_next = '0;
                cnt_next = '0;
            end
            teg_pkg::CMD_DIV_STEP:
            begin
                rem_next = div_ge ? X_W'(rem_sh - {1'b0, dx_reg}) : rem_sh[X_W-1:0];
                num_next = {num_reg[NUM_W-2:0], div_ge};
                cnt_next = CNT_W'(cnt_reg + 1'b1);
            end
            teg_pkg::CMD_INTERP:
            begin
                if (found_reg)
                    level_next = neg_reg ? Y_W'(y0_reg - num_reg[Y_W-1:0])
                                         : Y_W'(y0_reg + num_reg[Y_W-1:0]);
                else
                    level_next = prev_y_reg;
                if (pos_reg != '1)
                    pos_next = X_W'(pos_reg + 1'b1);
            end
            teg_pkg::CMD_END_FADE:
            begin
                if (pos_reg >= prev_x_reg)
                    phase_next = teg_pkg::PH_FADING;
                fc_next = fc_faded;
            end
            teg_pkg::CMD_LEND_CHECK:
            begin
                jump_next = loop_on_reg && (pos_reg >= rd_x);
            end
            teg_pkg::CMD_LSTART:
            begin
                if (jump_reg)
                    pos_next = rd_x;
            end
            teg_pkg::CMD_END_CHECK:
            begin
                if (pos_reg >= prev_x_reg)
                    phase_next = teg_pkg::PH_FADING;
            end
            teg_pkg::CMD_EMIT:
            begin
                out_valid_next       = 1'b1;
                out_data_next.level  = level_reg;
                out_data_next.phase  = phase_reg;
                out_data_next.active = act_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg  <= 4'd1;
            sustain_idx_reg <= '0;
            lstart_idx_reg  <= '0;
            lend_idx_reg    <= '0;
            env_on_reg      <= 1'b0;
            sus_on_reg      <= 1'b0;
            loop_on_reg     <= 1'b0;
            fade_step_reg   <= '0;
            pos_reg         <= '0;
            level_reg       <= teg_pkg::LEVEL_FULL;
            fc_reg          <= teg_pkg::FADE_FULL;
            phase_reg       <= teg_pkg::PH_FINISHED;
            act_reg         <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    teg_pkg::REG_NUM_POINTS: num_points_reg  <= cfg_data[3:0];
                    teg_pkg::REG_SUSTAIN:    sustain_idx_reg <= cfg_data[3:0];
                    teg_pkg::REG_LOOP_START: lstart_idx_reg  <= cfg_data[3:0];
                    teg_pkg::REG_LOOP_END:   lend_idx_reg    <= cfg_data[3:0];
                    teg_pkg::REG_ENV_ON:     env_on_reg      <= cfg_data[0];
                    teg_pkg::REG_SUS_ON:     sus_on_reg      <= cfg_data[0];
                    teg_pkg::REG_LOOP_ON:    loop_on_reg     <= cfg_data[0];
                    teg_pkg::REG_FADE_STEP:  fade_step_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            pos_reg       <= pos_next;
            level_reg     <= level_next;
            fc_reg        <= fc_next;
            phase_reg     <= phase_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        dp_reg       <= dp_next;
        dx_reg       <= dx_next;
        y0_reg       <= y0_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        found_reg    <= found_next;
        jump_reg     <= jump_next;
        idx_reg      <= idx_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign status.op         = in_data.op;
    assign status.phase      = phase_reg;
    assign status.env_on     = env_on_reg;
    assign status.sustain_on = sus_on_reg;
    assign status.sus_hit    = sus_on_reg && (pos_reg >= rd_x);
    assign status.scan_last  = (idx_reg == last_idx);
    assign status.found      = found_reg;
    assign status.div_last   = (cnt_reg == CNT_W'(NUM_W - 1));
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/teg_controller.sv
// ----------------------------------------------------------------------------
// teg_controller
// Sequencer that steps the datapath through one item at a time.
// ----------------------------------------------------------------------------
module teg_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  teg_pkg::status_t status,
    output teg_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SUS,
        S_SCAN,
        S_SCAN_DONE,
        S_DIV,
        S_INTERP,
        S_POST,
        S_LEND,
        S_LSTART,
        S_END,
        S_MUL_FLAT,
        S_MUL_LAST,
        S_MUL_LEVEL,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = teg_pkg::CMD_NONE;
        cmd.accept = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_OUT;
                    case (status.op)
                        teg_pkg::OP_LOAD:   cmd.op = teg_pkg::CMD_LOAD;
                        teg_pkg::OP_KEYOFF: cmd.op = teg_pkg::CMD_KEYOFF;
                        teg_pkg::OP_START:
                        begin
                            cmd.op     = teg_pkg::CMD_START_BEGIN;
                            state_next = S_START;
                        end
                        default:
                        begin
                            if (status.phase == teg_pkg::PH_FINISHED)
                                cmd.op = teg_pkg::CMD_FINISHED_TICK;
                            else if (!status.env_on)
                            begin
                                if (status.phase == teg_pkg::PH_RELEASING)
                                begin
                                    cmd.op     = teg_pkg::CMD_FADE;
                                    state_next = S_MUL_FLAT;
                                end
                                else
                                    cmd.op = teg_pkg::CMD_FLAT;
                            end
                            else if (status.phase == teg_pkg::PH_FADING)
                            begin
                                cmd.op     = teg_pkg::CMD_READ_LAST;
                                state_next = S_MUL_LAST;
                            end
                            else if (status.phase == teg_pkg::PH_SUSTAINING ||
                                     (status.phase == teg_pkg::PH_PLAYING && status.sustain_on))
                            begin
                                cmd.op     = teg_pkg::CMD_READ_SUS;
                                state_next = S_SUS;
                            end
                            else
                            begin
                                cmd.op     = teg_pkg::CMD_SCAN_INIT;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_START:
            begin
                cmd.op     = teg_pkg::CMD_START_LEVEL;
                state_next = S_OUT;
            end
            S_SUS:
            begin
                if (status.phase == teg_pkg::PH_SUSTAINING || status.sus_hit)
                begin
                    cmd.op     = teg_pkg::CMD_SUS_LEVEL;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = teg_pkg::CMD_SCAN_INIT;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = teg_pkg::CMD_SCAN_STEP;
                if (status.scan_last)
                    state_next = S_SCAN_DONE;
            end
            S_SCAN_DONE:
            begin
                if (status.found)
                begin
                    cmd.op     = teg_pkg::CMD_DIV_INIT;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.op     = teg_pkg::CMD_INTERP;
                    state_next = S_POST;
                end
            end
            S_DIV:
            begin
                cmd.op = teg_pkg::CMD_DIV_STEP;
                if (status.div_last)
                    state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.op     = teg_pkg::CMD_INTERP;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (status.phase == teg_pkg::PH_RELEASING)
                begin
                    cmd.op     = teg_pkg::CMD_END_FADE;
                    state_next = S_MUL_LEVEL;
                end
                else
                begin
                    cmd.op     = teg_pkg::CMD_READ_LEND;
                    state_next = S_LEND;
                end
            end
            S_LEND:
            begin
                cmd.op     = teg_pkg::CMD_LEND_CHECK;
                state_next = S_LSTART;
            end
            S_LSTART:
            begin
                cmd.op     = teg_pkg::CMD_LSTART;
                state_next = S_END;
            end
            S_END:
            begin
                cmd.op     = teg_pkg::CMD_END_CHECK;
                state_next = S_OUT;
            end
            S_MUL_FLAT:
            begin
                cmd.op     = teg_pkg::CMD_MUL_FLAT;
                state_next = S_OUT;
            end
            S_MUL_LAST:
            begin
                cmd.op     = teg_pkg::CMD_MUL_LAST;
                state_next = S_OUT;
            end
            S_MUL_LEVEL:
            begin
                cmd.op     = teg_pkg::CMD_MUL_LEVEL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = teg_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: rtl/tracker_envelope_generator_unit.sv
// A load or key-off beat goes from acceptance straight to the output state; a
// start beat first reads the level of point 0.
// The tick time is set by the segment scan (one table read per point) and the
// shift-subtract divider; one item is in flight at a time.
// Reset clears the envelope to finished, level 64, and the registers to their
// defaults; the point table holds no defined value until loaded.
// ----------------------------------------------------------------------------
// tracker_envelope_generator_unit
// Top level: controller and datapath of the tracker envelope generator.
// ----------------------------------------------------------------------------
module tracker_envelope_generator_unit #(
    parameter int MAX_POINTS = teg_pkg::MAX_POINTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  teg_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output teg_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [teg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [teg_pkg::CFG_DATA_W-1:0] cfg_data
);

    teg_pkg::cmd_t    cmd;
    teg_pkg::status_t status;

    teg_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    teg_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: rtl/teg_checker.sv
// ----------------------------------------------------------------------------
// teg_checker
// Port-level checks of the tracker envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module teg_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input teg_pkg::out_item_t             out_data
);

    // A beat that is taken keeps the block busy in the cycle after it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken right after an accepted beat");

    // An inactive result only comes from a finished envelope at level zero.
    a_inactive_finished: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.active |->
            out_data.phase == 3'(teg_pkg::PH_FINISHED) && out_data.level == '0)
        else $error("inactive result outside the finished phase");

    // A new result is only produced while an item is being worked on.
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the block was idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

endmodule

bind tracker_envelope_generator_unit teg_checker u_teg_checker (.*);
